// File: rtl/form_urlencoded_decoder_macros.svh
// Assertion macros used by the form-urlencoded decoder top level.
`ifndef FORM_URLENCODED_DECODER_MACROS_SVH
`define FORM_URLENCODED_DECODER_MACROS_SVH

// Condition implies consequence in the same cycle, checked outside reset.
`define FUD_ASSERT_IMP(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("fud: same-cycle check failed");

// Condition implies consequence in the following cycle, checked outside reset.
`define FUD_ASSERT_NXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("fud: next-cycle check failed");

`endif

// File: rtl/fud_pkg.sv
// Types, codes and helpers for the form-urlencoded decoder.
`default_nettype none
package fud_pkg;

  // Parser modes
  localparam logic [2:0] M_START = 3'd0;
  localparam logic [2:0] M_SKIP  = 3'd1;
  localparam logic [2:0] M_NAME  = 3'd2;
  localparam logic [2:0] M_VALUE = 3'd3;
  localparam logic [2:0] M_HEX1  = 3'd4;
  localparam logic [2:0] M_HEX2  = 3'd5;

  // Result kinds
  localparam logic [2:0] K_NAME_BYTE  = 3'd0;
  localparam logic [2:0] K_NAME_END   = 3'd1;
  localparam logic [2:0] K_VALUE_BYTE = 3'd2;
  localparam logic [2:0] K_PAIR_END   = 3'd3;
  localparam logic [2:0] K_DROPPED    = 3'd4;
  localparam logic [2:0] K_TEXT_END   = 3'd5;

  // Input actions
  localparam logic A_BYTE = 1'b0;
  localparam logic A_END  = 1'b1;

  // Special characters
  localparam logic [7:0] CH_AMP     = 8'h26; // '&'
  localparam logic [7:0] CH_EQ      = 8'h3D; // '='
  localparam logic [7:0] CH_PLUS    = 8'h2B; // '+'
  localparam logic [7:0] CH_PERCENT = 8'h25; // '%'
  localparam logic [7:0] CH_SPACE   = 8'h20; // ' '

  // Queue between parser and output stage
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // One queue entry: a first result, and when dual a trailing text end.
  typedef struct packed {
    logic       dual;
    logic [2:0] kind;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_stat_t;

  // Hex digit value; anything else counts as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/form_urlencoded_decoder.sv
// Form-urlencoded decoder top level: parser, entry queue and output stage.
//
// Input channel item_valid/item_ready/item carries one text byte
// (action 0) or an end-of-text marker (action 1) per transaction.
// Output channel result_valid/result_ready/result carries decoded name and
// value bytes plus name end, pair end, pair dropped and text end markers;
// last marks the final result caused by one input transaction.
// With an idle output, an accepted input is written into the queue and is
// then loaded into the output register, which raises result_valid.
// Throughput: one input per cycle while item_ready is high. An end-of-text
// item may yield two results, which leave the output register one after
// the other; the output register gives at most one result per cycle.
// A four-entry queue decouples the parser from the output register, so the
// parser keeps accepting while a result waits. item_ready drops only when
// that queue is full, as when the receiver stalls or two-result ends back up.
// Synchronous reset returns the parser to the start state and empties the
// queue and output register; nothing pending survives reset.
`default_nettype none
module form_urlencoded_decoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire fud_pkg::in_item_t  item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output fud_pkg::out_item_t      result
);
  import fud_pkg::*;
`include "form_urlencoded_decoder_macros.svh"

  logic    push;
  entry_t  push_entry;
  logic    pop;
  entry_t  head;
  q_stat_t q_stat;
  logic    pending;

  fud_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_stat.full),
    .push       (push),
    .push_entry (push_entry)
  );

  fud_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  fud_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_stat.empty),
    .pop          (pop),
    .pending      (pending),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A text end always closes the results of its input transaction
  `FUD_ASSERT_IMP(a_text_end_last, clk, rst, result_valid && result.kind == K_TEXT_END, result.last)
  // A held second result means the output register is occupied by the first
  `FUD_ASSERT_IMP(a_pending_busy, clk, rst, pending, result_valid && !result.last)
  // Queue never overflows its depth
  `FUD_ASSERT_IMP(a_q_bound, clk, rst, 1'b1, q_stat.count <= QCntW'(QDepth))
  // A pending second result is delivered as text end once taken
  `FUD_ASSERT_NXT(a_pending_text_end, clk, rst, pending && result_ready, result_valid && result.kind == K_TEXT_END)

endmodule
`default_nettype wire

// File: rtl/fud_front.sv
// Parser front: accepts input transactions, tracks mode, emits queue entries.
`default_nettype none
module fud_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire fud_pkg::in_item_t item,
  input  wire logic             q_full,
  output logic                  push,
  output fud_pkg::entry_t       push_entry
);
  import fud_pkg::*;

  logic [2:0] mode, mode_next;
  logic       esc_val, esc_val_next;
  logic [3:0] nibble, nibble_next;
  logic       has_res;
  logic       fire;
  logic [7:0] b;
  logic       in_value;
  logic [2:0] kb;

  assign item_ready = !q_full;
  assign fire       = item_valid && item_ready;
  assign push       = fire && has_res;
  assign b          = item.text_byte;
  assign in_value   = (mode == M_VALUE);
  assign kb         = in_value ? K_VALUE_BYTE : K_NAME_BYTE;

  // Next-state and result classification
  always_comb begin
    mode_next       = mode;
    esc_val_next    = esc_val;
    nibble_next     = nibble;
    has_res         = 1'b0;
    push_entry.dual = 1'b0;
    push_entry.kind = K_TEXT_END;
    push_entry.data = 8'd0;
    if (item.action == A_END) begin
      has_res         = 1'b1;
      push_entry.dual = 1'b1;
      unique case (mode)
        M_NAME, M_HEX1, M_HEX2: push_entry.kind = K_DROPPED;
        M_VALUE:                push_entry.kind = K_PAIR_END;
        default: begin
          push_entry.dual = 1'b0;
          push_entry.kind = K_TEXT_END;
        end
      endcase
      mode_next    = M_START;
      esc_val_next = 1'b0;
      nibble_next  = 4'd0;
    end else begin
      unique case (mode)
        M_SKIP: begin
          if (b == CH_AMP) mode_next = M_START;
        end
        M_NAME, M_VALUE: begin
          priority if (!in_value && b == CH_EQ) begin
            has_res         = 1'b1;
            push_entry.kind = K_NAME_END;
            mode_next       = M_VALUE;
          end else if (in_value && b == CH_AMP) begin
            has_res         = 1'b1;
            push_entry.kind = K_PAIR_END;
            mode_next       = M_START;
          end else if (b == CH_PLUS) begin
            has_res         = 1'b1;
            push_entry.kind = kb;
            push_entry.data = CH_SPACE;
          end else if (b == CH_PERCENT) begin
            esc_val_next = in_value;
            mode_next    = M_HEX1;
          end else begin
            has_res         = 1'b1;
            push_entry.kind = kb;
            push_entry.data = b;
          end
        end
        M_HEX1: begin
          nibble_next = hex_value(b);
          mode_next   = M_HEX2;
        end
        M_HEX2: begin
          has_res         = 1'b1;
          push_entry.data = {nibble, hex_value(b)};
          push_entry.kind = esc_val ? K_VALUE_BYTE : K_NAME_BYTE;
          mode_next       = esc_val ? M_VALUE : M_NAME;
        end
        default: begin
          // start, and the unused codes
          priority if (b == CH_AMP) begin
            mode_next = M_START;
          end else if (b == CH_EQ) begin
            mode_next = M_SKIP;
          end else begin
            has_res         = 1'b1;
            push_entry.kind = K_NAME_BYTE;
            push_entry.data = b;
            mode_next       = M_NAME;
          end
        end
      endcase
    end
  end

  // Parser state, updated only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_START;
      esc_val <= 1'b0;
      nibble  <= 4'd0;
    end else if (fire) begin
      mode    <= mode_next;
      esc_val <= esc_val_next;
      nibble  <= nibble_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fud_queue.sv
// Small FIFO of parsed entries between the parser and the output stage.
`default_nettype none
module fud_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire fud_pkg::entry_t push_entry,
  input  wire logic            pop,
  output fud_pkg::entry_t      head,
  output fud_pkg::q_stat_t     stat
);
  import fud_pkg::*;

  entry_t            slots [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;

  assign head       = slots[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == QCntW'(QDepth));
  assign stat.empty = (count == '0);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= QPtrW'((32'(wr_ptr) + 1) % QDepth);
      if (pop)  rd_ptr <= QPtrW'((32'(rd_ptr) + 1) % QDepth);
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/fud_back.sv
// Output stage: unpacks queue entries into result transactions.
`default_nettype none
module fud_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fud_pkg::entry_t  head,
  input  wire logic             q_empty,
  output logic                  pop,
  output logic                  pending,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output fud_pkg::out_item_t    result
);
  import fud_pkg::*;

  logic take;

  assign take = !result_valid || result_ready;
  assign pop  = take && !pending && !q_empty;

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pending      <= 1'b0;
    end else if (take) begin
      if (pending) begin
        result_valid <= 1'b1;
        pending      <= 1'b0;
      end else if (!q_empty) begin
        result_valid <= 1'b1;
        pending      <= head.dual;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (take) begin
      if (pending) begin
        result.kind     <= K_TEXT_END;
        result.out_byte <= 8'd0;
        result.last     <= 1'b1;
      end else if (!q_empty) begin
        result.kind     <= head.kind;
        result.out_byte <= head.data;
        result.last     <= !head.dual;
      end
    end
  end

endmodule
`default_nettype wire
